FILE: rtl/udiv64_pkg.sv
`default_nettype none

package udiv64_pkg;

    // Width of the dividend, divisor and quotient ports.
    localparam int PORT_WIDTH = 64;

    // Default width of the divide itself.
    localparam int DATA_WIDTH_DEF = 64;

    // Control that travels with each request along the row of cells.
    typedef struct packed {
        logic valid;
    } udiv64_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/unsigned_divide_64_top.sv
// Each request passes through the DATA_WIDTH cells of the row (64 by default).
// done is high with the result; the quotient is taken at the edge that ends the cycle.
// Throughput: one request per cycle; busy is always low, as each of the
// DATA_WIDTH cells in the row works out one quotient bit per cycle.
// The receiver cannot stall: the quotient is shown for exactly one cycle with done high.
// Reset clears the valid bits of every cell; done is low until the first
// request has passed through the whole row.
`default_nettype none

module unsigned_divide_64_top
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [PORT_WIDTH-1:0] dividend,
    input  wire logic [PORT_WIDTH-1:0] divisor,
    output logic                       done,
    output logic      [PORT_WIDTH-1:0] quotient
);

    localparam logic [PORT_WIDTH-1:0] WIDTH_MASK = PORT_WIDTH'({DATA_WIDTH{1'b1}});

    udiv64_ctl_t           ctl_row [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] rem_row [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] num_row [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] den_row [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] quo_row [DATA_WIDTH+1];

    // Bits above DATA_WIDTH are dropped on entry.
    assign ctl_row[0].valid = start;
    assign rem_row[0]       = '0;
    assign num_row[0]       = dividend[DATA_WIDTH-1:0];
    assign den_row[0]       = divisor[DATA_WIDTH-1:0];
    assign quo_row[0]       = '0;

    for (genvar i = 0; i < DATA_WIDTH; i++)
    begin : g_cell
        udiv64_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (ctl_row[i]),
            .rem_in  (rem_row[i]),
            .num_in  (num_row[i]),
            .den_in  (den_row[i]),
            .quo_in  (quo_row[i]),
            .ctl_out (ctl_row[i+1]),
            .rem_out (rem_row[i+1]),
            .num_out (num_row[i+1]),
            .den_out (den_row[i+1]),
            .quo_out (quo_row[i+1])
        );
    end

    assign busy     = 1'b0;
    assign done     = ctl_row[DATA_WIDTH].valid;
    assign quotient = PORT_WIDTH'(quo_row[DATA_WIDTH]);

`ifndef NO_ASSERTIONS
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((quotient & ~WIDTH_MASK) == '0))
        else $error("quotient has bits set above DATA_WIDTH");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (den_row[DATA_WIDTH] != '0))
            |-> (rem_row[DATA_WIDTH] < den_row[DATA_WIDTH]))
        else $error("final remainder is not below the divisor");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (den_row[DATA_WIDTH] == '0)) |-> (quotient == WIDTH_MASK))
        else $error("zero divisor did not give an all-ones quotient");
`endif

endmodule

`default_nettype wire

FILE: rtl/udiv64_cell.sv
`default_nettype none

module udiv64_cell
    import udiv64_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire udiv64_ctl_t           ctl_in,
    input  wire logic [DATA_WIDTH-1:0] rem_in,
    input  wire logic [DATA_WIDTH-1:0] num_in,
    input  wire logic [DATA_WIDTH-1:0] den_in,
    input  wire logic [DATA_WIDTH-1:0] quo_in,
    output udiv64_ctl_t                ctl_out,
    output logic      [DATA_WIDTH-1:0] rem_out,
    output logic      [DATA_WIDTH-1:0] num_out,
    output logic      [DATA_WIDTH-1:0] den_out,
    output logic      [DATA_WIDTH-1:0] quo_out
);

    udiv64_ctl_t           ctl_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] rem_next;
    logic [DATA_WIDTH-1:0] num_reg;
    logic [DATA_WIDTH-1:0] num_next;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] quo_next;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  carry;
    logic                  take;

    // One restoring step: bring in the next dividend bit and subtract the
    // divisor when the remainder, with its carry, is large enough.
    always_comb
    begin
        carry    = rem_in[DATA_WIDTH-1];
        shifted  = {rem_in[DATA_WIDTH-2:0], num_in[DATA_WIDTH-1]};
        diff     = {1'b0, shifted} - {1'b0, den_in};
        take     = carry | ~diff[DATA_WIDTH];
        rem_next = take ? diff[DATA_WIDTH-1:0] : shifted;
        num_next = {num_in[DATA_WIDTH-2:0], 1'b0};
        quo_next = {quo_in[DATA_WIDTH-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import udiv64_pkg::*;

    localparam int DIV_W = DATA_WIDTH_DEF;
    localparam logic [PORT_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [PORT_WIDTH-1:0] TOP_BIT = {1'b1, {(PORT_WIDTH-1){1'b0}}};
    localparam int RANDOM_REQUESTS = 1700;
    localparam int N_DIRECTED = 21;

    typedef struct {
        logic [PORT_WIDTH-1:0] dividend;
        logic [PORT_WIDTH-1:0] divisor;
        bit                    typed;
        logic [PORT_WIDTH-1:0] quotient;
    } division_case_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [PORT_WIDTH-1:0] dividend;
    logic [PORT_WIDTH-1:0] divisor;
    logic                  done;
    logic [PORT_WIDTH-1:0] quotient;

    logic [PORT_WIDTH-1:0] expected_quotients[$];
    int                    mismatch_count = 0;

    // Rows with typed set carry a quotient that can be read off directly;
    // the others are worked out by floor_quotient.
    division_case_t directed_cases [N_DIRECTED] = '{
        '{64'd0,                  64'd0,                  1'b1, ALL_ONES},
        '{ALL_ONES,               64'd0,                  1'b1, ALL_ONES},
        '{64'd12345,              64'd0,                  1'b1, ALL_ONES},
        '{64'd0,                  64'd1,                  1'b1, 64'd0},
        '{ALL_ONES,               64'd1,                  1'b1, ALL_ONES},
        '{ALL_ONES,               ALL_ONES,               1'b1, 64'd1},
        '{64'd0,                  ALL_ONES,               1'b1, 64'd0},
        '{64'd1,                  ALL_ONES,               1'b1, 64'd0},
        '{64'd1,                  64'd1,                  1'b1, 64'd1},
        '{TOP_BIT,                TOP_BIT + 64'd1,        1'b1, 64'd0},
        '{ALL_ONES - 64'd1,       ALL_ONES,               1'b1, 64'd0},
        '{ALL_ONES,               64'd2,                  1'b0, 64'd0},
        '{ALL_ONES,               TOP_BIT + 64'd1,        1'b0, 64'd0},
        '{ALL_ONES,               TOP_BIT,                1'b0, 64'd0},
        '{ALL_ONES,               ALL_ONES >> 1,          1'b0, 64'd0},
        '{TOP_BIT,                64'd3,                  1'b0, 64'd0},
        '{64'd100,                64'd7,                  1'b0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
        '{ALL_ONES,               64'hFFFF_FFFF,          1'b0, 64'd0},
        '{64'h0123_4567_89AB_CDEF, 64'h10,                 1'b0, 64'd0}
    };

    unsigned_divide_64_top #(
        .DATA_WIDTH (DIV_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("unsigned_divide_64_top verification failed");
        $finish;
    end

    // Restoring divide; a bit carried out of the partial remainder forces
    // the subtract, as a remainder one bit wider would.
    function automatic logic [PORT_WIDTH-1:0] floor_quotient(
        input logic [PORT_WIDTH-1:0] num_in,
        input logic [PORT_WIDTH-1:0] den_in
    );
        logic [DIV_W-1:0]      num;
        logic [DIV_W-1:0]      den;
        logic [DIV_W-1:0]      rem;
        logic [DIV_W-1:0]      quo;
        logic                  carry;
        logic [PORT_WIDTH-1:0] result;
        num = num_in[DIV_W-1:0];
        den = den_in[DIV_W-1:0];
        rem = '0;
        quo = '0;
        result = '0;
        if (den == '0)
        begin
            result[DIV_W-1:0] = '1;
            return result;
        end
        for (int i = DIV_W - 1; i >= 0; i--)
        begin
            carry = rem[DIV_W-1];
            rem = {rem[DIV_W-2:0], num[i]};
            if (carry || rem >= den)
            begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        result[DIV_W-1:0] = quo;
        return result;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(
        input string                 what,
        input logic [PORT_WIDTH-1:0] want,
        input logic [PORT_WIDTH-1:0] got
    );
        $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_quotients.size() == 0)
                report_mismatch("quotient with no request outstanding", '0, quotient);
            else if (quotient !== expected_quotients[0])
                report_mismatch("quotient", expected_quotients[0], quotient);
            if (expected_quotients.size() != 0)
                void'(expected_quotients.pop_front());
        end
    end

    // Holds the request on the ports until the edge that accepts it.
    task automatic send_request(
        input logic [PORT_WIDTH-1:0] num,
        input logic [PORT_WIDTH-1:0] den,
        input bit                    typed,
        input logic [PORT_WIDTH-1:0] typed_quotient
    );
        start    <= 1'b1;
        dividend <= num;
        divisor  <= den;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_quotients.push_back(typed ? typed_quotient : floor_quotient(num, den));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_quotients.size() != 0);
    endtask

    task automatic pick_operands(output logic [63:0] num, output logic [63:0] den);
        logic [63:0] k;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                num = rand_word();
                den = rand_word();
            end
            2:
            begin
                num = rand_word() >> $urandom_range(0, 63);
                den = '0;
            end
            3:
            begin
                // Divisor above half range exercises the carried remainder bit.
                num = rand_word() | TOP_BIT;
                den = rand_word() | TOP_BIT;
            end
            4:
            begin
                num = rand_word();
                den = 64'($urandom_range(1, 255));
            end
            5:
            begin
                den = rand_word() >> $urandom_range(1, 63);
                k   = rand_word() >> $urandom_range(1, 63);
                num = den * k + 64'($urandom_range(0, 3));
            end
            6:
            begin
                den = rand_word();
                num = den >> $urandom_range(0, 8);
                if ($urandom_range(0, 1) == 0)
                    num = den;
            end
            default:
            begin
                num = rand_word() >> $urandom_range(0, 63);
                den = rand_word() >> $urandom_range(0, 63);
            end
        endcase
    endtask

    initial
    begin
        logic [63:0] num;
        logic [63:0] den;
        int          burst_left;
        rst_n    = 1'b0;
        start    = 1'b0;
        dividend = '0;
        divisor  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cases[i])
            send_request(directed_cases[i].dividend, directed_cases[i].divisor,
                         directed_cases[i].typed, directed_cases[i].quotient);
        drain();

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == RANDOM_REQUESTS / 2)
                drain();
            if (burst_left == 0)
            begin
                // Mostly short bursts, now and then a long unbroken run.
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                         : $urandom_range(1, 30);
                idle_cycles($urandom_range(1, 70));
            end
            pick_operands(num, den);
            send_request(num, den, 1'b0, '0);
            burst_left--;
        end

        drain();
        repeat (DIV_W + 16) @(posedge clk);
        if (mismatch_count == 0)
            $display("unsigned_divide_64_top verification clean");
        else
            $display("unsigned_divide_64_top verification failed");
        $finish;
    end

endmodule
